FILE: hdl/psd_pkg.sv
package psd_pkg;

  // magic numbers as assembled little-endian from the first four bytes
  localparam logic [31:0] MAGIC_NATIVE  = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_SWAPPED = 32'hd4c3b2a1;

  localparam int unsigned GLOBAL_HDR_LEN = 24;
  localparam int unsigned RECORD_HDR_LEN = 16;

  // result kinds
  localparam logic [2:0] KIND_HDR_OK  = 3'd0;
  localparam logic [2:0] KIND_BAD_MAG = 3'd1;
  localparam logic [2:0] KIND_REC_HDR = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_DROPPED = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_PACKETS     = 2'd0;
  localparam logic [1:0] REG_MAX_CAPTURE_LEN = 2'd1;

  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [23:0] MAX_PACKETS_RST     = 24'd0;
  localparam logic [18:0] MAX_CAPTURE_LEN_RST = 19'd2048;

  typedef logic [31:0] word_t;

  function automatic word_t bswap32(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: hdl/pcap_stream_deframer_core.sv
// output: a result is loaded into the output register as the byte that causes it is taken
// throughput: one byte per cycle unless a held result stalls in_ready; the parse step is one
//   pass of compare, shift and 32-bit add logic between the state and output registers
// reset: synchronous active-low rst_n returns the parser to the global header phase,
//   clears counters and flags, and restores max_packets 0 and max_capture_len 2048
module pcap_stream_deframer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_kind,
  output logic [31:0]                         out_ts_sec,
  output logic [31:0]                         out_ts_usec,
  output logic [31:0]                         out_captured_len,
  output logic [31:0]                         out_wire_len,
  output logic [7:0]                          out_payload_value,
  output logic                                out_last_of_packet,
  output logic                                out_limit_reached,
  output logic [31:0]                         out_packet_count,
  output logic [31:0]                         out_total_bytes,
  output logic                                out_byte_swapped,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
  import psd_pkg::*;

  localparam logic [2:0] PH_GLOBAL  = 3'd0;
  localparam logic [2:0] PH_RECORD  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_STOPPED = 3'd4;

  localparam logic [4:0] GLOBAL_LAST_IDX = 5'(GLOBAL_HDR_LEN - 1);
  localparam logic [4:0] RECORD_LAST_IDX = 5'(RECORD_HDR_LEN - 1);

  logic [23:0] max_packets_r;
  logic [18:0] max_capture_len_r;

  logic [2:0]  phase_r, phase_nxt;
  logic        swap_r, swap_nxt;
  logic [4:0]  idx_r, idx_nxt;
  word_t       asm_r, asm_nxt;
  word_t       sec_r, sec_nxt;
  word_t       usec_r, usec_nxt;
  word_t       len_r, len_nxt;
  word_t       wire_r, wire_nxt;
  word_t       rem_r, rem_nxt;
  word_t       pkts_r, pkts_nxt;
  word_t       bytes_r, bytes_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r;
  word_t       ts_sec_r, ts_usec_r, cap_len_r, wire_len_r;
  logic [7:0]  pay_r;
  logic        last_r, lim_r;
  word_t       pkt_cnt_r, tot_bytes_r;
  logic        swapped_r;

  logic        in_xfer;
  logic        res_valid;
  logic [2:0]  res_kind;
  logic        res_rec;
  logic [7:0]  res_pay;
  logic        res_last;
  logic        res_lim;

  word_t       asm_shift;
  word_t       hdr_word;
  word_t       pkts_inc;
  logic        limit_now;
  logic        limit_done;
  logic        too_long;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // shared datapath terms
  assign asm_shift  = {in_data_byte, asm_r[31:8]};
  assign hdr_word   = swap_r ? bswap32(asm_shift) : asm_shift;
  assign pkts_inc   = pkts_r + 32'd1;
  assign limit_now  = (max_packets_r != '0) && (pkts_r >= {8'd0, max_packets_r});
  assign limit_done = (max_packets_r != '0) && (pkts_inc >= {8'd0, max_packets_r});
  assign too_long   = len_r > {13'd0, max_capture_len_r};

  // parse step for one byte
  always_comb begin
    phase_nxt = phase_r;
    swap_nxt  = swap_r;
    idx_nxt   = idx_r;
    asm_nxt   = asm_r;
    sec_nxt   = sec_r;
    usec_nxt  = usec_r;
    len_nxt   = len_r;
    wire_nxt  = wire_r;
    rem_nxt   = rem_r;
    pkts_nxt  = pkts_r;
    bytes_nxt = bytes_r;
    res_valid = 1'b0;
    res_kind  = KIND_HDR_OK;
    res_rec   = 1'b0;
    res_pay   = '0;
    res_last  = 1'b0;
    res_lim   = 1'b0;
    unique case (phase_r)
      PH_GLOBAL: begin
        asm_nxt = asm_shift;
        if (idx_r == 5'd3 && asm_shift != MAGIC_NATIVE && asm_shift != MAGIC_SWAPPED) begin
          phase_nxt = PH_STOPPED;
          res_valid = 1'b1;
          res_kind  = KIND_BAD_MAG;
        end else begin
          if (idx_r == 5'd3) begin
            swap_nxt = (asm_shift == MAGIC_SWAPPED);
          end
          idx_nxt = idx_r + 5'd1;
          if (idx_r == GLOBAL_LAST_IDX) begin
            idx_nxt   = '0;
            phase_nxt = PH_RECORD;
            res_valid = 1'b1;
            res_kind  = KIND_HDR_OK;
          end
        end
      end
      PH_RECORD: begin
        asm_nxt = asm_shift;
        if (idx_r == 5'd3)  sec_nxt  = hdr_word;
        if (idx_r == 5'd7)  usec_nxt = hdr_word;
        if (idx_r == 5'd11) len_nxt  = hdr_word;
        if (idx_r == 5'd15) wire_nxt = hdr_word;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == RECORD_LAST_IDX) begin
          idx_nxt   = '0;
          res_valid = 1'b1;
          res_rec   = 1'b1;
          priority if (too_long) begin
            // oversize record: report and skip its payload unless at the limit
            res_kind = KIND_DROPPED;
            res_lim  = limit_now;
            if (limit_now) begin
              phase_nxt = PH_STOPPED;
            end else begin
              phase_nxt = PH_SKIP;
              rem_nxt   = len_r;
            end
          end else if (len_r == '0) begin
            // empty record completes at once
            res_kind  = KIND_REC_HDR;
            res_last  = 1'b1;
            res_lim   = limit_done;
            pkts_nxt  = pkts_inc;
            bytes_nxt = bytes_r + len_r;
            phase_nxt = limit_done ? PH_STOPPED : PH_RECORD;
          end else begin
            res_kind  = KIND_REC_HDR;
            rem_nxt   = len_r;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_nxt   = rem_r - 32'd1;
        res_valid = 1'b1;
        res_rec   = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_pay   = in_data_byte;
        if (rem_r == 32'd1) begin
          res_last  = 1'b1;
          res_lim   = limit_done;
          pkts_nxt  = pkts_inc;
          bytes_nxt = bytes_r + len_r;
          phase_nxt = limit_done ? PH_STOPPED : PH_RECORD;
          idx_nxt   = '0;
        end
      end
      PH_SKIP: begin
        if (rem_r != '0) begin
          rem_nxt = rem_r - 32'd1;
        end
        if (rem_r <= 32'd1) begin
          phase_nxt = PH_RECORD;
          idx_nxt   = '0;
        end
      end
      default: begin
        // stopped: bytes are taken and ignored
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packets_r     <= MAX_PACKETS_RST;
      max_capture_len_r <= MAX_CAPTURE_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_PACKETS:     max_packets_r     <= cfg_wr_data[23:0];
        REG_MAX_CAPTURE_LEN: max_capture_len_r <= cfg_wr_data[18:0];
        default: begin
        end
      endcase
    end
  end

  // parser state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GLOBAL;
      swap_r  <= 1'b0;
      idx_r   <= '0;
      asm_r   <= '0;
      sec_r   <= '0;
      usec_r  <= '0;
      len_r   <= '0;
      wire_r  <= '0;
      rem_r   <= '0;
      pkts_r  <= '0;
      bytes_r <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      swap_r  <= swap_nxt;
      idx_r   <= idx_nxt;
      asm_r   <= asm_nxt;
      sec_r   <= sec_nxt;
      usec_r  <= usec_nxt;
      len_r   <= len_nxt;
      wire_r  <= wire_nxt;
      rem_r   <= rem_nxt;
      pkts_r  <= pkts_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, loaded when a result is produced
  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      kind_r      <= res_kind;
      ts_sec_r    <= res_rec ? sec_nxt  : '0;
      ts_usec_r   <= res_rec ? usec_nxt : '0;
      cap_len_r   <= res_rec ? len_nxt  : '0;
      wire_len_r  <= res_rec ? wire_nxt : '0;
      pay_r       <= res_pay;
      last_r      <= res_last;
      lim_r       <= res_lim;
      pkt_cnt_r   <= pkts_nxt;
      tot_bytes_r <= bytes_nxt;
      swapped_r   <= swap_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_ts_sec         = ts_sec_r;
  assign out_ts_usec        = ts_usec_r;
  assign out_captured_len   = cap_len_r;
  assign out_wire_len       = wire_len_r;
  assign out_payload_value  = pay_r;
  assign out_last_of_packet = last_r;
  assign out_limit_reached  = lim_r;
  assign out_packet_count   = pkt_cnt_r;
  assign out_total_bytes    = tot_bytes_r;
  assign out_byte_swapped   = swapped_r;

  // a packet ends only on a record header or payload byte
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> kind_r == KIND_REC_HDR || kind_r == KIND_PAYLOAD)
    else $error("last_of_packet on a result that cannot end a packet");

  // limit or bad magic leaves the parser stopped
  a_stop_after_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (lim_r || kind_r == KIND_BAD_MAG) |-> phase_r == PH_STOPPED)
    else $error("parser not stopped after limit or bad magic");

  // payload phase always has bytes left
  a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != '0)
    else $error("payload phase with no bytes remaining");

  // packet counter moves only with a packet-ending result
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    pkts_r != $past(pkts_r) |-> out_valid_r && last_r && pkts_r == pkt_cnt_r)
    else $error("packet count changed without a completed packet");

endmodule
